@@ rtl/amcp_pkg.sv @@
`default_nettype none
package amcp_pkg;

	localparam int LINE_DEPTH = 64;
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);

	localparam logic [2:0] KIND_FORWARD = 3'd0;
	localparam logic [2:0] KIND_TURN    = 3'd1;
	localparam logic [2:0] KIND_STOP    = 3'd2;
	localparam logic [2:0] KIND_SPEED   = 3'd3;
	localparam logic [2:0] KIND_ANGLE   = 3'd4;
	localparam logic [2:0] KIND_OTHER   = 3'd5;
	localparam logic [2:0] KIND_NONE    = 3'd6;

	localparam logic [1:0] ST_ACK      = 2'd0;
	localparam logic [1:0] ST_BADNUM   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN  = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [1:0] REG_FWD_DEF  = 2'd0;
	localparam logic [1:0] REG_TURN_DEF = 2'd1;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [95:0] PFX_FWD_SP  = 96'("FORWARD ");
	localparam logic [95:0] PFX_TURN_SP = 96'("TURN ");
	localparam logic [95:0] PFX_FWD     = 96'("FORWARD");
	localparam logic [95:0] PFX_STOP    = 96'("STOP");
	localparam logic [95:0] PFX_TURN    = 96'("TURN");
	localparam logic [95:0] PFX_SPEED   = 96'("SPEED=");
	localparam logic [95:0] PFX_ANGLE   = 96'({"ANGLE_", "SPEED="});

	localparam logic [3:0] LEN_FWD_SP  = 4'd8;
	localparam logic [3:0] LEN_TURN_SP = 4'd5;
	localparam logic [3:0] LEN_FWD     = 4'd7;
	localparam logic [3:0] LEN_STOP    = 4'd4;
	localparam logic [3:0] LEN_TURN    = 4'd4;
	localparam logic [3:0] LEN_SPEED   = 4'd6;
	localparam logic [3:0] LEN_ANGLE   = 4'd12;

	typedef struct packed {
		logic a_clr;
		logic a_step;
		logic b_init;
		logic b_step;
		logic c_step;
		logic load_res;
		logic load_ovf;
		logic [CW-1:0] idx;
		logic [CW-1:0] len;
	} dp_cmd_t;

	typedef struct packed {
		logic is_upper;
		logic is_lf;
		logic need_num;
		logic frac_go;
		logic [CW-1:0] num_start;
		logic [CW-1:0] frac_start;
	} dp_sts_t;

	// char at position idx of a prefix of length n still agrees (or lies past it)
	function automatic logic pfx_ok(input logic [95:0] s, input logic [3:0] n,
			input logic [CW-1:0] idx, input logic [7:0] c);
		logic [3:0] k;
		logic [95:0] sh;
		k = n - 4'd1 - idx[3:0];
		sh = s >> {k, 3'b000};
		return (idx >= CW'(n)) || (c == sh[7:0]);
	endfunction

endpackage
`default_nettype wire

@@ rtl/amcp_if.sv @@
`default_nettype none
interface amcp_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_char;
	modport source (output valid, output rx_char, input ready);
	modport sink (input valid, input rx_char, output ready);
endinterface

interface amcp_ord_if;
	logic valid;
	logic ready;
	logic [2:0] order_kind;
	logic [1:0] status;
	logic signed [31:0] value;
	modport source (output valid, output order_kind, output status, output value, input ready);
	modport sink (input valid, input order_kind, input status, input value, output ready);
endinterface

interface amcp_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/amcp_ram.sv @@
`default_nettype none
module amcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/amcp_ctrl.sv @@
`default_nettype none
module amcp_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       rx_valid,
	output logic                      rx_ready,
	output logic                      ord_valid,
	input  wire                       ord_ready,
	input  amcp_pkg::dp_sts_t         sts,
	output amcp_pkg::dp_cmd_t         cmd,
	output logic                      ram_we,
	output logic                      ram_re,
	output logic [amcp_pkg::AW-1:0]   ram_addr
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RECV  = 3'd1;
	localparam logic [2:0] S_SCANA = 3'd2;
	localparam logic [2:0] S_SCANB = 3'd3;
	localparam logic [2:0] S_SCANC = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam logic [amcp_pkg::CW-1:0] FULL = amcp_pkg::CW'(amcp_pkg::LINE_DEPTH - 1);

	logic [2:0] state_q, state_d;
	logic [amcp_pkg::CW-1:0] fill_q, fill_d, len_q, len_d, cnt_q, cnt_d, ridx_q, cnt_m1;
	logic rv_q, ov_q, ov_d, acc, issue;

	assign cnt_m1 = cnt_q - amcp_pkg::CW'(1);

	always_comb begin
		rx_ready = (state_q == S_IDLE || state_q == S_RECV) && (!ov_q || ord_ready);
		acc = rx_valid && rx_ready;
		state_d = state_q;
		fill_d = fill_q;
		len_d = len_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.idx = ridx_q;
		cmd.len = len_q;
		ram_we = 1'b0;
		issue = 1'b0;
		ram_addr = cnt_q[amcp_pkg::AW-1:0];

		case (state_q)
			S_IDLE: begin
				ram_addr = fill_q[amcp_pkg::AW-1:0];
				if (acc && sts.is_upper) begin
					ram_we = 1'b1;
					fill_d = amcp_pkg::CW'(1);
					state_d = S_RECV;
				end
			end
			S_RECV: begin
				ram_addr = fill_q[amcp_pkg::AW-1:0];
				if (acc) begin
					if (fill_q >= FULL) begin
						cmd.load_ovf = 1'b1;
						fill_d = '0;
						state_d = S_IDLE;
					end else if (sts.is_lf) begin
						cmd.a_clr = 1'b1;
						len_d = fill_q;
						fill_d = '0;
						cnt_d = '0;
						state_d = S_SCANA;
					end else begin
						ram_we = 1'b1;
						fill_d = fill_q + amcp_pkg::CW'(1);
					end
				end
			end
			S_SCANA, S_SCANB: begin
				issue = cnt_q < len_q;
				if (issue) begin
					cnt_d = cnt_q + amcp_pkg::CW'(1);
				end
				cmd.a_step = rv_q && state_q == S_SCANA;
				cmd.b_step = rv_q && state_q == S_SCANB;
				if (!issue && !rv_q) begin
					if (state_q == S_SCANA) begin
						if (sts.need_num) begin
							cmd.b_init = 1'b1;
							cnt_d = sts.num_start;
							state_d = S_SCANB;
						end else begin
							state_d = S_DONE;
						end
					end else if (sts.frac_go) begin
						cnt_d = len_q;
						state_d = S_SCANC;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCANC: begin
				// walk the fraction digits from the last one back to the point
				ram_addr = cnt_m1[amcp_pkg::AW-1:0];
				issue = cnt_q > sts.frac_start;
				if (issue) begin
					cnt_d = cnt_m1;
				end
				cmd.c_step = rv_q;
				if (!issue && !rv_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!ov_q || ord_ready) begin
					cmd.load_res = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		ram_re = issue;
		if (cmd.load_res || cmd.load_ovf) begin
			ov_d = 1'b1;
		end else if (ord_ready) begin
			ov_d = 1'b0;
		end else begin
			ov_d = ov_q;
		end
	end

	assign ord_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			ridx_q <= '0;
			rv_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q <= fill_d;
			len_q <= len_d;
			cnt_q <= cnt_d;
			ridx_q <= cnt_q;
			rv_q <= issue;
			ov_q <= ov_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/amcp_dpath.sv @@
`default_nettype none
module amcp_dpath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire [7:0]            rx_char,
	input  wire [7:0]            rd_char,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  wire [31:0]           cfg_data,
	input  amcp_pkg::dp_cmd_t    cmd,
	output amcp_pkg::dp_sts_t    sts,
	output logic [2:0]           order_kind,
	output logic [1:0]           status,
	output logic signed [31:0]   value
);
	localparam logic [2:0] PH_SP   = 3'd0;
	localparam logic [2:0] PH_WS   = 3'd1;
	localparam logic [2:0] PH_INT  = 3'd2;
	localparam logic [2:0] PH_FRAC = 3'd3;
	localparam logic [2:0] PH_BAD  = 3'd4;

	localparam logic [20:0] RECIP10 = 21'd1677722;

	logic [31:0] fwd_def_q, turn_def_q;
	logic m_fsp_q, m_tsp_q, m_f_q, m_stop_q, m_t_q, m_spd_q, m_ang_q, has_eq_q;
	logic h_fsp, h_tsp, h_f, h_stop, h_t, h_spd, h_ang;
	logic [2:0] ph_q, ph_eff, ph_d;
	logic neg_q, nd_q, any_q;
	logic [16:0] ip_q;
	logic [19:0] ip_x10;
	logic [15:0] fb_q;
	logic [amcp_pkg::CW-1:0] fs_q;
	logic is_dig, is_ws;
	logic [3:0] dig;
	logic [19:0] cx;
	logic [40:0] cprod;
	logic [32:0] mag;
	logic [31:0] num_val;
	logic [1:0] num_st;
	logic [2:0] res_kind;
	logic [1:0] res_st;
	logic [31:0] res_val;

	// a prefix counts only when the line is at least as long
	assign h_fsp  = m_fsp_q  && cmd.len >= amcp_pkg::CW'(amcp_pkg::LEN_FWD_SP);
	assign h_tsp  = m_tsp_q  && cmd.len >= amcp_pkg::CW'(amcp_pkg::LEN_TURN_SP);
	assign h_f    = m_f_q    && cmd.len >= amcp_pkg::CW'(amcp_pkg::LEN_FWD);
	assign h_stop = m_stop_q && cmd.len >= amcp_pkg::CW'(amcp_pkg::LEN_STOP);
	assign h_t    = m_t_q    && cmd.len >= amcp_pkg::CW'(amcp_pkg::LEN_TURN);
	assign h_spd  = m_spd_q  && cmd.len >= amcp_pkg::CW'(amcp_pkg::LEN_SPEED);
	assign h_ang  = m_ang_q  && cmd.len >= amcp_pkg::CW'(amcp_pkg::LEN_ANGLE);

	always_comb begin
		sts.is_upper = rx_char >= amcp_pkg::CH_A && rx_char <= amcp_pkg::CH_Z;
		sts.is_lf = rx_char == amcp_pkg::CH_LF;
		sts.frac_go = ph_q == PH_FRAC;
		sts.frac_start = fs_q;
		sts.need_num = 1'b1;
		sts.num_start = amcp_pkg::CW'(amcp_pkg::LEN_FWD_SP);
		if (h_fsp) begin
			sts.num_start = amcp_pkg::CW'(amcp_pkg::LEN_FWD_SP);
		end else if (h_tsp) begin
			sts.num_start = amcp_pkg::CW'(amcp_pkg::LEN_TURN);
		end else if (h_f || h_stop || h_t) begin
			sts.need_num = 1'b0;
		end else if (h_spd) begin
			sts.num_start = amcp_pkg::CW'(amcp_pkg::LEN_SPEED);
		end else if (h_ang) begin
			sts.num_start = amcp_pkg::CW'(amcp_pkg::LEN_ANGLE);
		end else begin
			sts.need_num = 1'b0;
		end
	end

	assign is_dig = rd_char >= amcp_pkg::CH_0 && rd_char <= amcp_pkg::CH_9;
	assign is_ws = rd_char == amcp_pkg::CH_SPACE || (rd_char >= 8'h09 && rd_char <= 8'h0D);
	assign dig = 4'(rd_char - amcp_pkg::CH_0);
	assign ip_x10 = {ip_q, 3'b000} + {2'b00, ip_q, 1'b0} + 20'(dig);

	always_comb begin
		ph_eff = (ph_q == PH_SP && rd_char != amcp_pkg::CH_SPACE) ? PH_WS : ph_q;
		ph_d = ph_eff;
		case (ph_eff)
			PH_SP: ph_d = PH_SP;
			PH_WS: begin
				if (is_ws) begin
					ph_d = PH_WS;
				end else if (rd_char == amcp_pkg::CH_PLUS || rd_char == amcp_pkg::CH_MINUS
						|| is_dig) begin
					ph_d = PH_INT;
				end else if (rd_char == amcp_pkg::CH_DOT) begin
					ph_d = PH_FRAC;
				end else begin
					ph_d = PH_BAD;
				end
			end
			PH_INT: begin
				if (is_dig) begin
					ph_d = PH_INT;
				end else if (rd_char == amcp_pkg::CH_DOT) begin
					ph_d = PH_FRAC;
				end else begin
					ph_d = PH_BAD;
				end
			end
			PH_FRAC: ph_d = is_dig ? PH_FRAC : PH_BAD;
			PH_BAD: ph_d = PH_BAD;
			default: ph_d = PH_BAD;
		endcase
	end

	// fb = floor((65536*d + fb) / 10), the quotient by reciprocal multiply
	assign cx = {dig, 16'h0000} + 20'(fb_q);
	assign cprod = 41'(cx) * 41'(RECIP10);

	always_comb begin
		mag = {ip_q, 16'h0000} + 33'(fb_q);
		if (neg_q) begin
			num_val = (mag > 33'h080000000) ? 32'h80000000 : 32'(33'd0 - mag);
		end else begin
			num_val = (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
		end
		if (!any_q || ph_q == PH_SP) begin
			num_st = amcp_pkg::ST_ACK;
			num_val = '0;
		end else if (ph_q == PH_BAD || !nd_q) begin
			num_st = amcp_pkg::ST_BADNUM;
			num_val = '0;
		end else begin
			num_st = amcp_pkg::ST_ACK;
		end

		res_val = '0;
		res_st = amcp_pkg::ST_ACK;
		if (h_fsp) begin
			res_kind = amcp_pkg::KIND_FORWARD;
			res_st = num_st;
			res_val = num_val;
		end else if (h_tsp) begin
			res_kind = amcp_pkg::KIND_TURN;
			res_st = num_st;
			res_val = num_val;
		end else if (h_f) begin
			res_kind = amcp_pkg::KIND_FORWARD;
			res_val = fwd_def_q;
		end else if (h_stop) begin
			res_kind = amcp_pkg::KIND_STOP;
		end else if (h_t) begin
			res_kind = amcp_pkg::KIND_TURN;
			res_val = turn_def_q;
		end else if (h_spd) begin
			res_kind = amcp_pkg::KIND_SPEED;
			res_st = num_st;
			res_val = num_val;
		end else if (h_ang) begin
			res_kind = amcp_pkg::KIND_ANGLE;
			res_st = num_st;
			res_val = num_val;
		end else if (has_eq_q) begin
			res_kind = amcp_pkg::KIND_OTHER;
		end else begin
			res_kind = amcp_pkg::KIND_NONE;
			res_st = amcp_pkg::ST_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_def_q <= 32'h00010000;
			turn_def_q <= 32'h00010000;
		end else if (cfg_we) begin
			if (cfg_index == amcp_pkg::REG_FWD_DEF) begin
				fwd_def_q <= cfg_data;
			end else if (cfg_index == amcp_pkg::REG_TURN_DEF) begin
				turn_def_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.a_clr) begin
			{m_fsp_q, m_tsp_q, m_f_q, m_stop_q, m_t_q, m_spd_q, m_ang_q} <= '1;
			has_eq_q <= 1'b0;
		end else if (cmd.a_step) begin
			m_fsp_q  <= m_fsp_q  && amcp_pkg::pfx_ok(amcp_pkg::PFX_FWD_SP,
					amcp_pkg::LEN_FWD_SP, cmd.idx, rd_char);
			m_tsp_q  <= m_tsp_q  && amcp_pkg::pfx_ok(amcp_pkg::PFX_TURN_SP,
					amcp_pkg::LEN_TURN_SP, cmd.idx, rd_char);
			m_f_q    <= m_f_q    && amcp_pkg::pfx_ok(amcp_pkg::PFX_FWD,
					amcp_pkg::LEN_FWD, cmd.idx, rd_char);
			m_stop_q <= m_stop_q && amcp_pkg::pfx_ok(amcp_pkg::PFX_STOP,
					amcp_pkg::LEN_STOP, cmd.idx, rd_char);
			m_t_q    <= m_t_q    && amcp_pkg::pfx_ok(amcp_pkg::PFX_TURN,
					amcp_pkg::LEN_TURN, cmd.idx, rd_char);
			m_spd_q  <= m_spd_q  && amcp_pkg::pfx_ok(amcp_pkg::PFX_SPEED,
					amcp_pkg::LEN_SPEED, cmd.idx, rd_char);
			m_ang_q  <= m_ang_q  && amcp_pkg::pfx_ok(amcp_pkg::PFX_ANGLE,
					amcp_pkg::LEN_ANGLE, cmd.idx, rd_char);
			has_eq_q <= has_eq_q || rd_char == amcp_pkg::CH_EQ;
		end

		if (cmd.b_init) begin
			ph_q <= h_tsp ? PH_SP : PH_WS;
			neg_q <= 1'b0;
			nd_q <= 1'b0;
			any_q <= 1'b0;
			ip_q <= '0;
			fb_q <= '0;
			fs_q <= '0;
		end else if (cmd.b_step) begin
			ph_q <= ph_d;
			any_q <= 1'b1;
			if (ph_eff == PH_WS && rd_char == amcp_pkg::CH_MINUS) begin
				neg_q <= 1'b1;
			end
			if (is_dig && (ph_eff == PH_WS || ph_eff == PH_INT)) begin
				nd_q <= 1'b1;
				ip_q <= (ip_x10 > 20'd65536) ? 17'd65536 : ip_x10[16:0];
			end
			if (is_dig && ph_eff == PH_FRAC) begin
				nd_q <= 1'b1;
			end
			if (ph_d == PH_FRAC && ph_eff != PH_FRAC) begin
				fs_q <= cmd.idx + amcp_pkg::CW'(1);
			end
		end else if (cmd.c_step) begin
			fb_q <= cprod[39:24];
		end

		if (cmd.load_ovf) begin
			order_kind <= amcp_pkg::KIND_NONE;
			status <= amcp_pkg::ST_OVERFLOW;
			value <= '0;
		end else if (cmd.load_res) begin
			order_kind <= res_kind;
			status <= res_st;
			value <= res_val;
		end
	end
endmodule
`default_nettype wire

@@ rtl/ascii_motion_command_parser_unit.sv @@
// Receive: one character per cycle while idle or collecting a line; input stalls during the
// decode and while a finished result waits with ord.ready low.
// Decode: after the newline the single line RAM read port is walked over the line for the prefix,
// then over the numeric tail, then back over the fraction digits, and the result is registered.
// An overflow result shows right after the beat of the overflowing char.
// Reset (arst_n low) returns to idle with no result pending; both defaults read 1.0 (Q16.16).
`default_nettype none
module ascii_motion_command_parser_unit (
	input wire        clk,
	input wire        arst_n,
	amcp_rx_if.sink   rx,
	amcp_ord_if.source ord,
	amcp_cfg_if.sink  cfg
);
	amcp_pkg::dp_cmd_t cmd;
	amcp_pkg::dp_sts_t sts;
	logic ram_we, ram_re;
	logic [amcp_pkg::AW-1:0] ram_addr;
	logic [7:0] rd_char;

	assign cfg.ready = 1'b1;

	amcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx.valid),
		.rx_ready  (rx.ready),
		.ord_valid (ord.valid),
		.ord_ready (ord.ready),
		.sts       (sts),
		.cmd       (cmd),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr)
	);

	amcp_ram #(
		.WIDTH (8),
		.DEPTH (amcp_pkg::LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (rx.rx_char),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (rd_char)
	);

	amcp_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_char    (rx.rx_char),
		.rd_char    (rd_char),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.cmd        (cmd),
		.sts        (sts),
		.order_kind (ord.order_kind),
		.status     (ord.status),
		.value      (ord.value)
	);
endmodule
`default_nettype wire

@@ tb/ascii_motion_command_parser_unit_tb.sv @@
`timescale 1ns / 1ps
module ascii_motion_command_parser_unit_tb;

	localparam string ANG_PFX = {"ANGLE_", "SPEED="};

	typedef struct {
		logic [2:0]  kind;
		logic [1:0]  st;
		logic [31:0] val;
	} order_t;

	class order_scoreboard;
		bit          receiving;
		int unsigned fill;
		bit [7:0]    line_buf[amcp_pkg::LINE_DEPTH];
		bit [31:0]   fwd_def = 32'h0001_0000;
		bit [31:0]   turn_def = 32'h0001_0000;
		order_t      pending[$];
		int          errors;
		int          checked;
		int          overflows;
		int          badnums;

		function bit starts_with(int len, string s);
			for (int i = 0; i < s.len(); i++)
				if (i >= len || line_buf[i] != s[i]) return 0;
			return 1;
		endfunction

		function bit is_space(bit [7:0] c);
			return c == amcp_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		function bit is_num(bit [7:0] c);
			return c >= amcp_pkg::CH_0 && c <= amcp_pkg::CH_9;
		endfunction

		// decimal text -> Q16.16, fraction truncated, saturated
		function logic [1:0] to_fixed(int p, int len, output bit [31:0] v);
			int q, nd, nf, carry, t;
			bit neg;
			bit [31:0] ip, fb;
			bit [63:0] mag;
			int fd[amcp_pkg::LINE_DEPTH];
			q = p; nd = 0; nf = 0; neg = 0; ip = 0; fb = 0; v = 0;
			while (q < len && is_space(line_buf[q])) q++;
			if (q < len && (line_buf[q] == amcp_pkg::CH_PLUS
					|| line_buf[q] == amcp_pkg::CH_MINUS)) begin
				neg = line_buf[q] == amcp_pkg::CH_MINUS;
				q++;
			end
			while (q < len && is_num(line_buf[q])) begin
				ip = ip * 10 + (line_buf[q] - amcp_pkg::CH_0);
				if (ip > 65536) ip = 65536;
				nd++; q++;
			end
			if (q < len && line_buf[q] == amcp_pkg::CH_DOT) begin
				q++;
				while (q < len && is_num(line_buf[q]) && nf < amcp_pkg::LINE_DEPTH) begin
					fd[nf] = line_buf[q] - amcp_pkg::CH_0;
					nf++; nd++; q++;
				end
			end
			if (nd == 0) return (p >= len) ? amcp_pkg::ST_ACK : amcp_pkg::ST_BADNUM;
			if (q != len) return amcp_pkg::ST_BADNUM;
			for (int k = 0; k < 16; k++) begin
				carry = 0;
				for (int i = nf; i > 0; i--) begin
					t = fd[i-1] * 2 + carry;
					fd[i-1] = t % 10;
					carry = t / 10;
				end
				fb = (fb << 1) | 32'(carry);
			end
			mag = ({32'd0, ip} << 16) + 64'(fb);
			if (neg) begin
				if (mag > 64'h8000_0000) mag = 64'h8000_0000;
				v = 32'd0 - mag[31:0];
			end else begin
				if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
				v = mag[31:0];
			end
			return amcp_pkg::ST_ACK;
		endfunction

		function order_t decode_line(int len);
			order_t o;
			int p;
			o.val = 0;
			o.st = amcp_pkg::ST_ACK;
			if (starts_with(len, "FORWARD ")) begin
				o.kind = amcp_pkg::KIND_FORWARD;
				o.st = to_fixed(8, len, o.val);
			end else if (starts_with(len, "TURN ")) begin
				p = 4;
				while (p < len && line_buf[p] == amcp_pkg::CH_SPACE) p++;
				o.kind = amcp_pkg::KIND_TURN;
				o.st = to_fixed(p, len, o.val);
			end else if (starts_with(len, "FORWARD")) begin
				o.kind = amcp_pkg::KIND_FORWARD;
				o.val = fwd_def;
			end else if (starts_with(len, "STOP")) begin
				o.kind = amcp_pkg::KIND_STOP;
			end else if (starts_with(len, "TURN")) begin
				o.kind = amcp_pkg::KIND_TURN;
				o.val = turn_def;
			end else if (starts_with(len, "SPEED=")) begin
				o.kind = amcp_pkg::KIND_SPEED;
				o.st = to_fixed(6, len, o.val);
			end else if (starts_with(len, ANG_PFX)) begin
				o.kind = amcp_pkg::KIND_ANGLE;
				o.st = to_fixed(12, len, o.val);
			end else begin
				o.kind = amcp_pkg::KIND_NONE;
				o.st = amcp_pkg::ST_UNKNOWN;
				for (int i = 0; i < len; i++)
					if (line_buf[i] == amcp_pkg::CH_EQ) begin
						o.kind = amcp_pkg::KIND_OTHER;
						o.st = amcp_pkg::ST_ACK;
						break;
					end
			end
			return o;
		endfunction

		function void note_char(bit [7:0] c);
			order_t o;
			if (!receiving) begin
				if (c >= amcp_pkg::CH_A && c <= amcp_pkg::CH_Z) begin
					line_buf[0] = c;
					fill = 1;
					receiving = 1;
				end
				return;
			end
			if (fill >= amcp_pkg::LINE_DEPTH - 1) begin
				receiving = 0;
				fill = 0;
				o.kind = amcp_pkg::KIND_NONE; o.st = amcp_pkg::ST_OVERFLOW; o.val = 0;
				pending.push_back(o);
				overflows++;
				return;
			end
			if (c == amcp_pkg::CH_LF) begin
				o = decode_line(fill);
				receiving = 0;
				fill = 0;
				if (o.st == amcp_pkg::ST_BADNUM) badnums++;
				pending.push_back(o);
				return;
			end
			line_buf[fill] = c;
			fill++;
		endfunction

		function void check_order(logic [2:0] kind, logic [1:0] st, logic [31:0] val);
			order_t e;
			if (pending.size() == 0) begin
				$error("unexpected order: kind %0d status %0d value %h", kind, st, val);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (kind !== e.kind) begin
				$error("order_kind: expected %0d, got %0d", e.kind, kind);
				errors++;
			end
			if (st !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, st);
				errors++;
			end
			if (val !== e.val) begin
				$error("value: expected %h, got %h", e.val, val);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;

	amcp_rx_if  rx();
	amcp_ord_if ord();
	amcp_cfg_if cfg();

	ascii_motion_command_parser_unit u_dut (
		.clk(clk), .arst_n(arst_n), .rx(rx), .ord(ord), .cfg(cfg)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	order_scoreboard sb = new();
	bit       calm;
	bit       hold_req;
	int       n_chars;
	int       n_lines;
	bit [7:0] line_q[$];

	always @(posedge clk) begin
		if (rx.valid === 1'b1 && rx.ready === 1'b1) sb.note_char(rx.rx_char);
		if (ord.valid === 1'b1 && ord.ready === 1'b1)
			sb.check_order(ord.order_kind, ord.status, ord.value);
	end

	// order sink: random stalls, one long hold-off on request
	initial begin
		int n;
		ord.ready <= 1'b0;
		forever begin
			if (hold_req) begin
				n = 400;
				hold_req = 0;
			end else if (calm) begin
				n = 0;
			end else begin
				n = $urandom_range(0, 12);
			end
			if (n > 0) begin
				ord.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			ord.ready <= 1'b1;
			do @(posedge clk); while (ord.valid !== 1'b1);
		end
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic send_char(bit [7:0] c);
		int n;
		n = calm ? 0 : $urandom_range(0, 12);
		if (n > 0) begin
			rx.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		rx.valid   <= 1'b1;
		rx.rx_char <= c;
		do @(posedge clk); while (rx.ready !== 1'b1);
		n_chars++;
	endtask

	task automatic send_queue();
		foreach (line_q[i]) send_char(line_q[i]);
		line_q.delete();
		n_lines++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
		line_q.push_back(amcp_pkg::CH_LF);
		send_queue();
	endtask

	task automatic drain();
		rx.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] d);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		if (idx == amcp_pkg::REG_FWD_DEF) sb.fwd_def = d;
		else sb.turn_def = d;
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
	endtask

	task automatic push_number();
		int n;
		if ($urandom_range(0, 5) == 0) push_text($urandom_range(0, 1) ? " " : "\t");
		case ($urandom_range(0, 3))
			0: push_text("-");
			1: push_text("+");
			default: ;
		endcase
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
		repeat (n) line_q.push_back(8'(amcp_pkg::CH_0 + $urandom_range(0, 9)));
		if ($urandom_range(0, 1)) begin
			line_q.push_back(amcp_pkg::CH_DOT);
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 25) : $urandom_range(0, 8);
			repeat (n) line_q.push_back(8'(amcp_pkg::CH_0 + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 7) == 0)
			case ($urandom_range(0, 5))
				0: push_text("e5");
				1: push_text("x1F");
				2: push_text("inf");
				3: push_text(" ");
				4: push_text("nan");
				default: line_q.push_back(8'($urandom_range(0, 255) & 8'hF7));
			endcase
	endtask

	function automatic bit [7:0] body_byte();
		bit [7:0] c;
		c = 8'($urandom_range(0, 255));
		return (c == amcp_pkg::CH_LF) ? 8'h0B : c;
	endfunction

	task automatic random_line();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0, 1, 2: begin push_text("FORWARD "); push_number(); end
			3, 4: begin
				push_text("TURN");
				repeat ($urandom_range(1, 3)) push_text(" ");
				push_number();
			end
			5: push_text($urandom_range(0, 1) ? "FORWARD" : "FORWARDX");
			6: push_text($urandom_range(0, 1) ? "STOP" : "STOP NOW");
			7: push_text($urandom_range(0, 1) ? "TURN" : "TURNED");
			8, 9, 10: begin push_text("SPEED="); push_number(); end
			11, 12: begin push_text(ANG_PFX); push_number(); end
			13: push_text($urandom_range(0, 1) ? "KP=3.5" : "LIMIT=");
			14: begin
				// rare: a long line that mostly runs past the line buffer
				line_q.push_back(8'(amcp_pkg::CH_A + $urandom_range(0, 25)));
				repeat ($urandom_range(60, 80)) line_q.push_back(body_byte());
			end
			default: begin
				line_q.push_back(8'(amcp_pkg::CH_A + $urandom_range(0, 25)));
				repeat ($urandom_range(0, 20)) line_q.push_back(body_byte());
			end
		endcase
		line_q.push_back(amcp_pkg::CH_LF);
	endtask

	initial begin
		bit [7:0] c;
		int start;
		rx.valid   <= 1'b0;
		rx.rx_char <= 8'h00;
		cfg.valid  <= 1'b0;
		cfg.index  <= amcp_pkg::REG_FWD_DEF;
		cfg.data   <= 32'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_text("FORWARD 12.5");
		send_text("FORWARD -32768.99999");
		send_text("FORWARD");
		send_text("STOP");
		send_text("TURN   -90.25");
		send_text("TURN");
		send_text("SPEED=");
		send_text("SPEED= ");
		send_text("SPEED=99999999");
		send_text({ANG_PFX, "-40000.5"});
		send_text("SPEED=1e3");
		send_text("SPEED=0x10");
		send_text("KP=3");
		send_text("HELLO");
		line_q = '{8'h5A, 8'h00, 8'h3D, 8'hFF};
		line_q.push_back(amcp_pkg::CH_LF);
		send_queue();
		push_text("QQ");
		repeat (70) line_q.push_back(8'h71);
		line_q.push_back(amcp_pkg::CH_LF);
		send_queue();

		write_reg(amcp_pkg::REG_FWD_DEF, 32'h7FFF_FFFF);
		write_reg(amcp_pkg::REG_TURN_DEF, 32'h8000_0000);
		send_text("FORWARD");
		send_text("TURN");

		start = n_chars;
		while (n_chars - start < 800) begin
			if (n_chars - start > 250 && sb.fwd_def == 32'h7FFF_FFFF) begin
				write_reg(amcp_pkg::REG_FWD_DEF, $urandom());
				write_reg(amcp_pkg::REG_TURN_DEF, $urandom());
			end
			if (n_chars - start > 550 && sb.turn_def != 32'd0) begin
				write_reg(amcp_pkg::REG_FWD_DEF, 32'h8000_0000);
				write_reg(amcp_pkg::REG_TURN_DEF, 32'd0);
			end
			if (n_lines % 40 == 20) hold_req = 1;
			calm = (n_lines % 30) < 4;
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3)) begin
					c = 8'($urandom_range(0, 255));
					if (c >= amcp_pkg::CH_A && c <= amcp_pkg::CH_Z) c = c | 8'h20;
					send_char(c);
					n_chars--;
				end
			random_line();
			send_queue();
		end
		calm = 0;
		drain();

		$display("Sent %0d characters in %0d lines; %0d orders checked", n_chars, n_lines,
			sb.checked);
		$display("including %0d buffer overflows and %0d bad numbers", sb.overflows,
			sb.badnums);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

@@ ascii_motion_command_parser_unit.f @@
rtl/amcp_pkg.sv
rtl/amcp_if.sv
rtl/amcp_ram.sv
rtl/amcp_ctrl.sv
rtl/amcp_dpath.sv
rtl/ascii_motion_command_parser_unit.sv
tb/ascii_motion_command_parser_unit_tb.sv
